FILE: rtl/mrlp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrlp_pkg
// Shared types and character codes for the modem response line parser.
// ----------------------------------------------------------------------------
package mrlp_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [2:0] kind_type;
   typedef logic [1:0] sms_stage_type;

   // request codes carried on req_tuser
   localparam logic REQ_BYTE      = 1'b0;
   localparam logic REQ_SMS_CLEAR = 1'b1;

   // result kinds carried on rsp_tuser
   localparam kind_type KIND_PROMPT    = 3'd0;
   localparam kind_type KIND_OK        = 3'd1;
   localparam kind_type KIND_SMS_HDR   = 3'd2;
   localparam kind_type KIND_SMS_FIRST = 3'd3;
   localparam kind_type KIND_SMS_LATER = 3'd4;
   localparam kind_type KIND_GENERAL   = 3'd5;

   // sms progress
   localparam sms_stage_type SMS_NONE  = 2'd0;
   localparam sms_stage_type SMS_FIRST = 2'd1;
   localparam sms_stage_type SMS_LATER = 2'd2;

   // characters
   localparam byte_type CHAR_LF     = 8'd10;
   localparam byte_type CHAR_CR     = 8'd13;
   localparam byte_type CHAR_PROMPT = 8'h3E;
   localparam byte_type CHAR_O      = 8'h4F;
   localparam byte_type CHAR_K      = 8'h4B;
   localparam byte_type CHAR_PLUS   = 8'h2B;
   localparam byte_type CHAR_C      = 8'h43;
   localparam byte_type CHAR_M      = 8'h4D;
   localparam byte_type CHAR_T      = 8'h54;

   // leading characters kept beside the store for the pattern tests
   localparam int HEAD_DEPTH = 5;

endpackage : mrlp_pkg
`default_nettype wire

FILE: rtl/mrlp_line_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrlp_line_store
// Line buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mrlp_line_store #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire                   clock,
   input  wire                   wr_en,
   input  wire  [AW-1:0]         wr_addr,
   input  mrlp_pkg::byte_type    wr_data,
   input  wire                   rd_en,
   input  wire  [AW-1:0]         rd_addr,
   output mrlp_pkg::byte_type    rd_data
);
   import mrlp_pkg::*;

   byte_type mem [DEPTH];
   byte_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : mrlp_line_store
`default_nettype wire

FILE: rtl/modem_response_line_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modem_response_line_parser
// Frames modem receive bytes into CR LF terminated lines and classifies them.
// ----------------------------------------------------------------------------
// Each transfer on req that carries a stored byte, a CR, a prompt or an
// sms clear is handled as it is accepted. A line end that matches OK or
// +CMT gives its single result from the output register in the next cycle.
// Any other line end streams the stored line out of the line store byte by
// byte (read, then load the output register), and req_tready stays low
// until the last byte is loaded. The output register holds one result; while
// that result waits on rsp_tready, req_tready stays low as well. There is no
// clearing pass after reset.
module modem_response_line_parser #(
   parameter int LINE_DEPTH = 64
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   input  wire  [7:0]          req_tdata,   // [7:0] rx_byte
   input  wire                 req_tuser,   // [0] req_type
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   output logic [15:0]         rsp_tdata,   // [7:0] line_byte, [8] overflowed
   output logic [2:0]          rsp_tuser,   // [2:0] kind
   output logic                rsp_tlast
);
   import mrlp_pkg::*;

   localparam int AW = $clog2(LINE_DEPTH);
   localparam int LW = $clog2(LINE_DEPTH + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_LOAD = 2'd2;

   logic [1:0]     state_ff, state_in;
   logic [LW-1:0]  len_ff, len_in;
   logic           cr_ff, cr_in;
   logic           ovf_ff, ovf_in;
   sms_stage_type  sms_ff, sms_in;
   byte_type       head_ff [HEAD_DEPTH];

   logic [LW-1:0]  idx_ff, idx_in;
   logic [LW-1:0]  drain_len_ff, drain_len_in;
   kind_type       drain_kind_ff, drain_kind_in;
   logic           drain_ovf_ff, drain_ovf_in;

   logic           rsp_valid_ff, rsp_valid_in;
   kind_type       rsp_kind_ff, rsp_kind_in;
   byte_type       rsp_byte_ff, rsp_byte_in;
   logic           rsp_last_ff, rsp_last_in;
   logic           rsp_ovf_ff, rsp_ovf_in;

   logic           slot_free;
   logic           accept;
   byte_type       rx;
   logic           is_clear;
   logic           line_end;
   logic           ok_match;
   logic           sms_match;
   logic           store_room;
   logic           store_wr;
   logic           mem_rd;
   byte_type       mem_rd_data;
   logic           drain_last;

   function automatic logic head_is(input logic [LW-1:0] len, input byte_type ch_at,
                                    input int pos, input byte_type ch);
      return (len > LW'(pos)) && (ch_at == ch);
   endfunction

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;
   assign rx         = req_tdata;
   assign is_clear   = (req_tuser == REQ_SMS_CLEAR);
   assign line_end   = (rx == CHAR_LF) && cr_ff && (len_ff != '0);
   assign store_room = (len_ff < LW'(LINE_DEPTH));

   assign ok_match  = (head_is(len_ff, head_ff[0], 0, CHAR_O) &&
                       head_is(len_ff, head_ff[1], 1, CHAR_K)) ||
                      (head_is(len_ff, head_ff[1], 1, CHAR_O) &&
                       head_is(len_ff, head_ff[2], 2, CHAR_K));
   assign sms_match = head_is(len_ff, head_ff[1], 1, CHAR_PLUS) &&
                      head_is(len_ff, head_ff[2], 2, CHAR_C) &&
                      head_is(len_ff, head_ff[3], 3, CHAR_M) &&
                      head_is(len_ff, head_ff[4], 4, CHAR_T);

   assign store_wr   = accept && !is_clear && !line_end && (rx != CHAR_CR) &&
                       (rx != CHAR_PROMPT) && store_room;
   assign mem_rd     = (state_ff == ST_READ);
   assign drain_last = ((idx_ff + LW'(1)) == drain_len_ff);

   mrlp_line_store #(
      .DEPTH (LINE_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr),
      .wr_addr (len_ff[AW-1:0]),
      .wr_data (rx),
      .rd_en   (mem_rd),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      cr_in         = cr_ff;
      ovf_in        = ovf_ff;
      sms_in        = sms_ff;
      idx_in        = idx_ff;
      drain_len_in  = drain_len_ff;
      drain_kind_in = drain_kind_ff;
      drain_ovf_in  = drain_ovf_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_clear) begin
                  sms_in = SMS_NONE;
               end else if (line_end) begin
                  len_in = '0;
                  cr_in  = 1'b0;
                  ovf_in = 1'b0;
                  if (ok_match || sms_match) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = ok_match ? KIND_OK : KIND_SMS_HDR;
                     rsp_byte_in  = '0;
                     rsp_last_in  = 1'b1;
                     rsp_ovf_in   = ovf_ff;
                     if (!ok_match) begin
                        sms_in = SMS_FIRST;
                     end
                  end else begin
                     state_in     = ST_READ;
                     idx_in       = '0;
                     drain_len_in = len_ff;
                     drain_ovf_in = ovf_ff;
                     case (sms_ff)
                        SMS_FIRST: begin
                           drain_kind_in = KIND_SMS_FIRST;
                           sms_in        = SMS_LATER;
                        end
                        SMS_LATER: drain_kind_in = KIND_SMS_LATER;
                        default:   drain_kind_in = KIND_GENERAL;
                     endcase
                  end
               end else if (rx == CHAR_CR) begin
                  cr_in = 1'b1;
               end else begin
                  cr_in = 1'b0;
                  if (rx == CHAR_PROMPT) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_PROMPT;
                     rsp_byte_in  = '0;
                     rsp_last_in  = 1'b1;
                     rsp_ovf_in   = 1'b0;
                  end else if (store_room) begin
                     len_in = len_ff + LW'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = drain_kind_ff;
               rsp_byte_in  = mem_rd_data;
               rsp_last_in  = drain_last;
               rsp_ovf_in   = drain_ovf_ff;
               idx_in       = idx_ff + LW'(1);
               state_in     = drain_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         cr_ff        <= 1'b0;
         ovf_ff       <= 1'b0;
         sms_ff       <= SMS_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         cr_ff        <= cr_in;
         ovf_ff       <= ovf_in;
         sms_ff       <= sms_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      drain_len_ff  <= drain_len_in;
      drain_kind_ff <= drain_kind_in;
      drain_ovf_ff  <= drain_ovf_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   // leading characters copied beside the store for the pattern tests
   always_ff @(posedge clock) begin
      for (int i = 0; i < HEAD_DEPTH; i++) begin
         if (store_wr && (len_ff == LW'(i))) begin
            head_ff[i] <= rx;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {7'd0, rsp_ovf_ff, rsp_byte_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule : modem_response_line_parser
`default_nettype wire

FILE: dv/modem_response_line_parser_tb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modem_response_line_parser_tb
// Self-checking bench for the modem response line parser. A queue of modem
// receive bytes and sms clears feeds a stream driver; every accepted transfer
// is run through a behavioural line parser that queues the results due, and a
// monitor compares each result transfer with the oldest one due. A directed
// opening covers ok lines at both offsets, the +CMT header, sms stages, the
// prompt, the stray LF and the CR mark; random lines, long overflowing lines
// and noise follow under varying idle patterns and a long receiver hold-off.
// ----------------------------------------------------------------------------
module modem_response_line_parser_tb;

   import mrlp_pkg::*;

   localparam int LINE_DEPTH = 64;

   typedef struct packed {
      logic     pause;
      logic     req_type;
      byte_type rx_byte;
   } rx_item_type;

   typedef struct packed {
      kind_type kind;
      byte_type line_byte;
      logic     last;
      logic     overflowed;
   } line_result_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;   // [7:0] rx_byte
   logic        req_tuser  = 1'b0;   // [0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [7:0] line_byte, [8] overflowed
   logic [2:0]  rsp_tuser;           // [2:0] kind
   logic        rsp_tlast;

   rx_item_type     rx_stream[$];
   line_result_type due_results[$];
   int              rx_total    = 0;
   int              sent_items  = 0;
   int              fault_count = 0;
   int              hold_left   = 0;
   logic            hold_done   = 1'b0;

   // parser state
   byte_type      line_buf [0:LINE_DEPTH-1];
   int            line_len  = 0;
   logic          cr_mark   = 1'b0;
   logic          ovf_mark  = 1'b0;
   sms_stage_type sms_state = SMS_NONE;

   modem_response_line_parser #(
      .LINE_DEPTH(LINE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic holds(input int pos, input byte_type ch);
      return (pos < line_len) && (line_buf[pos] == ch);
   endfunction

   function automatic void push_due(input kind_type k, input byte_type b,
                                    input logic l, input logic o);
      line_result_type r;
      r.kind       = k;
      r.line_byte  = b;
      r.last       = l;
      r.overflowed = o;
      due_results.push_back(r);
   endfunction

   function automatic void parse_rx_byte(input logic req_type, input byte_type rx);
      kind_type run_kind;
      if (req_type == REQ_SMS_CLEAR) begin
         sms_state = SMS_NONE;
      end else if (rx == CHAR_LF && cr_mark && line_len > 0) begin
         if ((holds(0, CHAR_O) && holds(1, CHAR_K)) ||
             (holds(1, CHAR_O) && holds(2, CHAR_K))) begin
            push_due(KIND_OK, 8'd0, 1'b1, ovf_mark);
         end else if (holds(1, CHAR_PLUS) && holds(2, CHAR_C) &&
                      holds(3, CHAR_M) && holds(4, CHAR_T)) begin
            push_due(KIND_SMS_HDR, 8'd0, 1'b1, ovf_mark);
            sms_state = SMS_FIRST;
         end else begin
            if (sms_state == SMS_FIRST) begin
               run_kind  = KIND_SMS_FIRST;
               sms_state = SMS_LATER;
            end else if (sms_state == SMS_LATER) begin
               run_kind = KIND_SMS_LATER;
            end else begin
               run_kind = KIND_GENERAL;
            end
            for (int i = 0; i < line_len; i++)
               push_due(run_kind, line_buf[i], i == line_len - 1, ovf_mark);
         end
         line_len = 0;
         cr_mark  = 1'b0;
         ovf_mark = 1'b0;
      end else if (rx == CHAR_CR) begin
         cr_mark = 1'b1;
      end else begin
         cr_mark = 1'b0;
         if (rx == CHAR_PROMPT) begin
            push_due(KIND_PROMPT, 8'd0, 1'b1, 1'b0);
         end else if (line_len < LINE_DEPTH) begin
            line_buf[line_len] = rx;
            line_len++;
         end else begin
            ovf_mark = 1'b1;
         end
      end
   endfunction

   task automatic push_byte(input byte_type b);
      rx_item_type it;
      it.pause    = 1'b0;
      it.req_type = REQ_BYTE;
      it.rx_byte  = b;
      rx_stream.push_back(it);
      rx_total++;
   endtask

   task automatic push_clear();
      rx_item_type it;
      it.pause    = 1'b0;
      it.req_type = REQ_SMS_CLEAR;
      it.rx_byte  = byte_type'($urandom_range(255));
      rx_stream.push_back(it);
      rx_total++;
   endtask

   task automatic push_pause();
      rx_item_type it;
      it.pause    = 1'b1;
      it.req_type = REQ_BYTE;
      it.rx_byte  = 8'd0;
      rx_stream.push_back(it);
   endtask

   task automatic push_eol();
      push_byte(CHAR_CR);
      push_byte(CHAR_LF);
   endtask

   task automatic push_ok();
      push_byte(CHAR_O);
      push_byte(CHAR_K);
   endtask

   task automatic push_cmt();
      push_byte(CHAR_PLUS);
      push_byte(CHAR_C);
      push_byte(CHAR_M);
      push_byte(CHAR_T);
   endtask

   task automatic push_text(input int n);
      for (int i = 0; i < n; i++)
         push_byte(byte_type'($urandom_range(255)));
   endtask

   // line breaks weighted heavily so that stray LF and dangling CR turn up
   task automatic push_noise(input int n);
      int sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(3);
         if (sel == 0)
            push_byte(CHAR_CR);
         else if (sel == 1)
            push_byte(CHAR_LF);
         else
            push_byte(byte_type'($urandom_range(255)));
      end
   endtask

   function automatic int req_gap_pct();
      if (sent_items < rx_total / 3)
         return 17;
      else if (sent_items < 2 * rx_total / 3)
         return 53;
      return 0;
   endfunction

   function automatic int rsp_gap_pct();
      if (sent_items < rx_total / 3)
         return 53;
      else if (sent_items < 2 * rx_total / 3)
         return 17;
      return 0;
   endfunction

   // byte driver
   always @(posedge clock) begin
      rx_item_type nxt;
      logic        offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            parse_rx_byte(req_tuser, req_tdata);
            sent_items <= sent_items + 1;
         end
         if (!req_tvalid || req_tready) begin
            offer = 1'b0;
            if (rx_stream.size() > 0 && rx_stream[0].pause) begin
               if (due_results.size() == 0)
                  nxt = rx_stream.pop_front();
            end else if (rx_stream.size() > 0 &&
                         $urandom_range(99) >= req_gap_pct()) begin
               nxt       = rx_stream.pop_front();
               offer     = 1'b1;
               req_tdata <= nxt.rx_byte;
               req_tuser <= nxt.req_type;
            end
            req_tvalid <= offer;
         end
      end
   end

   // receiver ready, with one long hold-off late in the run
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && sent_items >= (3 * rx_total) / 4) begin
         hold_done  <= 1'b1;
         hold_left  <= 600;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_gap_pct());
      end
   end

   // result monitor
   always @(posedge clock) begin
      line_result_type seen;
      line_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.kind       = rsp_tuser;
         seen.line_byte  = rsp_tdata[7:0];
         seen.last       = rsp_tlast;
         seen.overflowed = rsp_tdata[8];
         if (due_results.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("%0t: unexpected transfer kind=%0d byte=%02h last=%b ovf=%b",
                        $realtime, seen.kind, seen.line_byte, seen.last,
                        seen.overflowed);
         end else begin
            want = due_results.pop_front();
            if (seen !== want) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("%0t: mismatch exp kind=%0d byte=%02h last=%b ovf=%b,",
                           $realtime, want.kind, want.line_byte, want.last,
                           want.overflowed,
                           " got kind=%0d byte=%02h last=%b ovf=%b",
                           seen.kind, seen.line_byte, seen.last,
                           seen.overflowed);
            end
         end
      end
   end

   initial begin
      int pick;
      int long_lines;
      int pauses;
      long_lines = 0;
      pauses     = 0;

      // directed opening
      push_ok();
      push_eol();
      push_byte(CHAR_LF);
      push_cmt();
      push_eol();
      push_byte(CHAR_PROMPT);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_eol();
      push_eol();
      push_ok();
      push_eol();
      push_byte(CHAR_CR);
      push_byte(CHAR_C);
      push_eol();
      push_clear();
      push_byte(CHAR_T);
      push_eol();
      push_pause();

      // one overflowing line straight away
      push_text(70);
      push_eol();
      long_lines = 1;

      while (rx_total < 210) begin
         if ((pauses == 0 && rx_total >= 80) || (pauses == 1 && rx_total >= 150)) begin
            push_pause();
            pauses++;
         end
         pick = $urandom_range(99);
         if (pick < 14) begin
            if ($urandom_range(1))
               push_eol();
            push_ok();
            push_text($urandom_range(3));
            push_eol();
         end else if (pick < 28) begin
            if ($urandom_range(3) == 0)
               push_text(1);
            else
               push_eol();
            push_cmt();
            push_text($urandom_range(8));
            push_eol();
            repeat ($urandom_range(3, 1)) begin
               push_text($urandom_range(10, 1));
               push_eol();
            end
            if ($urandom_range(1))
               push_clear();
         end else if (pick < 58) begin
            push_text($urandom_range(12, 1));
            push_eol();
         end else if (pick < 62 && long_lines < 3) begin
            if ($urandom_range(1)) begin
               push_byte(CHAR_LF);
               push_cmt();
               push_text($urandom_range(68, 62));
            end else begin
               push_text($urandom_range(72, 64));
            end
            push_eol();
            long_lines++;
         end else if (pick < 70) begin
            push_byte(CHAR_PROMPT);
         end else if (pick < 78) begin
            push_clear();
         end else begin
            push_noise($urandom_range(4, 1));
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      do
         @(posedge clock);
      while (rx_stream.size() != 0 || req_tvalid || due_results.size() != 0);
      repeat (200) @(posedge clock);

      if (fault_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule : modem_response_line_parser_tb
`default_nettype wire

FILE: modem_response_line_parser.f
rtl/mrlp_pkg.sv
rtl/mrlp_line_store.sv
rtl/modem_response_line_parser.sv
dv/modem_response_line_parser_tb.sv
